// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the point rotation RTL.
// Used by the trig unit, the rotation stage and the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define PTR_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define PTR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/ptr_pkg.sv =====
// Package for the point rotation block: widths, types, register codes,
// series reciprocal tables and the round/saturate helper. No dependencies.
package ptr_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 16;
  localparam int COORD_W        = 32;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int PROD_W         = COORD_W + TRIG_W;
  localparam int SUM_W          = PROD_W + 1;
  localparam int NUM_AXES       = 3;
  localparam int RSH            = 30 - TRIG_FRAC_BITS;
  localparam int RHALF          = (RSH > 0) ? (1 << (RSH - 1)) : 0;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [2:0]  SERIES_TERMS = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [TRIG_W-1:0]  trig_val_t;
  typedef logic [ANGLE_BITS-1:0]     angle_t;
  typedef logic [1:0]                axis_t;

  localparam axis_t REG_ANGLE_X = 2'd0;
  localparam axis_t REG_ANGLE_Y = 2'd1;
  localparam axis_t REG_ANGLE_Z = 2'd2;

  typedef struct packed {
    trig_val_t [NUM_AXES-1:0] sin_v;
    trig_val_t [NUM_AXES-1:0] cos_v;
  } trig_set_t;

  // floor(n/d) for n < 2^30 is (n * mult) >> (30 + sh),
  // with sh = ceil(log2 d) and mult = ceil(2^(30+sh) / d)
  typedef struct packed {
    logic [30:0] mult;
    logic [3:0]  sh;
  } recip_t;

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_PREP,
    TS_XMUL,
    TS_X2,
    TS_TMUL,
    TS_DIV,
    TS_SMUL,
    TS_DONE
  } trig_state_t;

  // divisor 2k(2k+1)
  function automatic recip_t sin_recip(input logic [2:0] k);
    recip_t r;
    unique case (k)
      3'd1:    r = '{mult: 31'(((64'd1 << 33) + 64'd5) / 64'd6),     sh: 4'd3};
      3'd2:    r = '{mult: 31'(((64'd1 << 35) + 64'd19) / 64'd20),   sh: 4'd5};
      3'd3:    r = '{mult: 31'(((64'd1 << 36) + 64'd41) / 64'd42),   sh: 4'd6};
      3'd4:    r = '{mult: 31'(((64'd1 << 37) + 64'd71) / 64'd72),   sh: 4'd7};
      3'd5:    r = '{mult: 31'(((64'd1 << 37) + 64'd109) / 64'd110), sh: 4'd7};
      3'd6:    r = '{mult: 31'(((64'd1 << 38) + 64'd155) / 64'd156), sh: 4'd8};
      3'd7:    r = '{mult: 31'(((64'd1 << 38) + 64'd209) / 64'd210), sh: 4'd8};
      default: r = '{mult: Q30_ONE, sh: 4'd0};
    endcase
    return r;
  endfunction

  // divisor (2k-1)2k
  function automatic recip_t cos_recip(input logic [2:0] k);
    recip_t r;
    unique case (k)
      3'd1:    r = '{mult: 31'(((64'd1 << 31) + 64'd1) / 64'd2),     sh: 4'd1};
      3'd2:    r = '{mult: 31'(((64'd1 << 34) + 64'd11) / 64'd12),   sh: 4'd4};
      3'd3:    r = '{mult: 31'(((64'd1 << 35) + 64'd29) / 64'd30),   sh: 4'd5};
      3'd4:    r = '{mult: 31'(((64'd1 << 36) + 64'd55) / 64'd56),   sh: 4'd6};
      3'd5:    r = '{mult: 31'(((64'd1 << 37) + 64'd89) / 64'd90),   sh: 4'd7};
      3'd6:    r = '{mult: 31'(((64'd1 << 38) + 64'd131) / 64'd132), sh: 4'd8};
      3'd7:    r = '{mult: 31'(((64'd1 << 38) + 64'd181) / 64'd182), sh: 4'd8};
      default: r = '{mult: Q30_ONE, sh: 4'd0};
    endcase
    return r;
  endfunction

  // Round half up at TRIG_FRAC_BITS (floor shift), then saturate to 32 bits.
  function automatic coord_t finish(input logic signed [SUM_W-1:0] acc);
    logic signed [SUM_W:0]                  t;
    logic signed [SUM_W-TRIG_FRAC_BITS:0]   r;
    coord_t                                 res;
    t = (SUM_W+1)'(acc) + (SUM_W+1)'(1 << (TRIG_FRAC_BITS - 1));
    r = t[SUM_W:TRIG_FRAC_BITS];
    if ((r[SUM_W-TRIG_FRAC_BITS:COORD_W-1] == '0) ||
        (r[SUM_W-TRIG_FRAC_BITS:COORD_W-1] == '1)) begin
      res = r[COORD_W-1:0];
    end else if (r[SUM_W-TRIG_FRAC_BITS]) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ===== hdl/ptr_trig.sv =====
// Sine/cosine unit: recomputes one axis after each angle write using a
// shared multiplier and reciprocal-multiply division. Depends on ptr_pkg.
`include "assert_macros.svh"

module ptr_trig (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       wr_en,
  input  ptr_pkg::axis_t                             wr_axis,
  input  ptr_pkg::angle_t [ptr_pkg::NUM_AXES-1:0]    angles,
  output logic                                       busy,
  output ptr_pkg::trig_set_t                         trig
);
  import ptr_pkg::*;

  trig_state_t state_r, state_nxt;
  logic [NUM_AXES-1:0] pend_r, pend_nxt, pend_set, pend_clr;
  axis_t       axis_r, axis_nxt;
  logic [1:0]  quad_r, quad_nxt;
  logic        swap_r, swap_nxt;
  logic [21:0] u_r, u_nxt;
  logic [29:0] x_r, x_nxt;
  logic [29:0] x2_r, x2_nxt;
  logic [30:0] ts_r, ts_nxt, tc_r, tc_nxt;
  logic [2:0]  k_r, k_nxt;
  logic        sel_r, sel_nxt;
  logic [29:0] dvd_r, dvd_nxt;
  logic [30:0] s30_r, s30_nxt;
  trig_set_t   trig_r, trig_nxt;

  logic [30:0] mul_a, mul_b;
  logic [61:0] prod;
  logic [23:0] a24;
  recip_t      rcp;
  logic [29:0] quo;
  logic [31:0] rs_sum, rc_sum;
  logic [TRIG_FRAC_BITS:0] s_mag, c_mag, sm, cm;
  trig_val_t   sm_s, cm_s;

  assign busy = (state_r != TS_IDLE) || (|pend_r) || wr_en;
  assign trig = trig_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      TS_IDLE: if (|pend_r) state_nxt = TS_PREP;
      TS_PREP: state_nxt = TS_XMUL;
      TS_XMUL: state_nxt = TS_X2;
      TS_X2:   state_nxt = TS_TMUL;
      TS_TMUL: state_nxt = TS_DIV;
      TS_DIV: begin
        if (sel_r && (k_r == 3'd1)) state_nxt = TS_SMUL;
        else                        state_nxt = TS_TMUL;
      end
      TS_SMUL: state_nxt = TS_DONE;
      TS_DONE: state_nxt = TS_IDLE;
      default: state_nxt = TS_IDLE;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    unique case (state_r)
      TS_XMUL: begin mul_a = 31'(u_r);  mul_b = HALF_PI_Q30; end
      TS_X2:   begin mul_a = 31'(x_r);  mul_b = 31'(x_r);    end
      TS_TMUL: begin mul_a = 31'(x2_r); mul_b = sel_r ? tc_r : ts_r; end
      TS_DIV:  begin mul_a = 31'(dvd_r); mul_b = rcp.mult;   end
      TS_SMUL: begin mul_a = 31'(x_r);  mul_b = ts_r;        end
      default: begin mul_a = '0;        mul_b = '0;          end
    endcase
  end
  assign prod = 62'(mul_a) * 62'(mul_b);

  assign a24 = 24'(angles[axis_r]) << (24 - ANGLE_BITS);
  assign rcp = sel_r ? cos_recip(k_r) : sin_recip(k_r);
  assign quo = 30'(prod >> (6'd30 + 6'(rcp.sh)));

  assign rs_sum = 32'(s30_r) + 32'(RHALF);
  assign rc_sum = 32'(tc_r) + 32'(RHALF);
  assign s_mag  = (TRIG_FRAC_BITS+1)'(rs_sum >> RSH);
  assign c_mag  = (TRIG_FRAC_BITS+1)'(rc_sum >> RSH);
  assign sm     = swap_r ? c_mag : s_mag;
  assign cm     = swap_r ? s_mag : c_mag;
  assign sm_s   = trig_val_t'({1'b0, sm});
  assign cm_s   = trig_val_t'({1'b0, cm});

  always_comb begin
    pend_set = '0;
    if (wr_en && (wr_axis < axis_t'(NUM_AXES))) pend_set[wr_axis] = 1'b1;
  end

  // datapath next values
  always_comb begin
    pend_clr = '0;
    axis_nxt = axis_r;
    quad_nxt = quad_r;
    swap_nxt = swap_r;
    u_nxt    = u_r;
    x_nxt    = x_r;
    x2_nxt   = x2_r;
    ts_nxt   = ts_r;
    tc_nxt   = tc_r;
    k_nxt    = k_r;
    sel_nxt  = sel_r;
    dvd_nxt  = dvd_r;
    s30_nxt  = s30_r;
    trig_nxt = trig_r;
    unique case (state_r)
      TS_IDLE: begin
        priority if (pend_r[REG_ANGLE_X]) axis_nxt = REG_ANGLE_X;
        else if (pend_r[REG_ANGLE_Y])     axis_nxt = REG_ANGLE_Y;
        else                              axis_nxt = REG_ANGLE_Z;
        if (|pend_r) pend_clr[axis_nxt] = 1'b1;
      end
      TS_PREP: begin
        quad_nxt = a24[23:22];
        swap_nxt = a24[21];
        u_nxt    = a24[21] ? 22'(23'h40_0000 - 23'(a24[21:0])) : a24[21:0];
      end
      TS_XMUL: x_nxt = prod[51:22];
      TS_X2: begin
        x2_nxt  = prod[59:30];
        ts_nxt  = Q30_ONE;
        tc_nxt  = Q30_ONE;
        k_nxt   = SERIES_TERMS;
        sel_nxt = 1'b0;
      end
      TS_TMUL: dvd_nxt = prod[59:30];
      TS_DIV: begin
        if (sel_r) tc_nxt = Q30_ONE - 31'(quo);
        else       ts_nxt = Q30_ONE - 31'(quo);
        sel_nxt = ~sel_r;
        if (sel_r) k_nxt = k_r - 3'd1;
      end
      TS_SMUL: s30_nxt = prod[60:30];
      TS_DONE: begin
        unique case (quad_r)
          2'd0: begin trig_nxt.sin_v[axis_r] = sm_s;  trig_nxt.cos_v[axis_r] = cm_s;  end
          2'd1: begin trig_nxt.sin_v[axis_r] = cm_s;  trig_nxt.cos_v[axis_r] = -sm_s; end
          2'd2: begin trig_nxt.sin_v[axis_r] = -sm_s; trig_nxt.cos_v[axis_r] = -cm_s; end
          2'd3: begin trig_nxt.sin_v[axis_r] = -cm_s; trig_nxt.cos_v[axis_r] = sm_s;  end
          default: ;
        endcase
      end
      default: ;
    endcase
    pend_nxt = (pend_r & ~pend_clr) | pend_set;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TS_IDLE;
      pend_r  <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        trig_r.sin_v[i] <= '0;
        trig_r.cos_v[i] <= trig_val_t'(1 << TRIG_FRAC_BITS);
      end
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      trig_r  <= trig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    axis_r <= axis_nxt;
    quad_r <= quad_nxt;
    swap_r <= swap_nxt;
    u_r    <= u_nxt;
    x_r    <= x_nxt;
    x2_r   <= x2_nxt;
    ts_r   <= ts_nxt;
    tc_r   <= tc_nxt;
    k_r    <= k_nxt;
    sel_r  <= sel_nxt;
    dvd_r  <= dvd_nxt;
    s30_r  <= s30_nxt;
  end

  `PTR_ASSERT_NEXT(a_wr_sets_busy, wr_en && (wr_axis < axis_t'(NUM_AXES)), busy)
  `PTR_ASSERT_ALWAYS(a_div_k_range, (state_r != TS_DIV) || (k_r != 3'd0))

endmodule

// ===== hdl/ptr_rot.sv =====
// One plane rotation: a' = a*c - b*s, b' = a*s + b*c, as a multiply stage
// and a round/saturate stage with per-stage handshake. Depends on ptr_pkg.
`include "assert_macros.svh"

module ptr_rot (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptr_pkg::coord_t    a_i,
  input  ptr_pkg::coord_t    b_i,
  input  ptr_pkg::coord_t    p_i,
  input  ptr_pkg::trig_val_t sin_i,
  input  ptr_pkg::trig_val_t cos_i,
  output logic               out_valid,
  input  logic               out_ready,
  output ptr_pkg::coord_t    a_o,
  output ptr_pkg::coord_t    b_o,
  output ptr_pkg::coord_t    p_o
);
  import ptr_pkg::*;

  typedef logic signed [PROD_W-1:0] prod_t;

  logic   v1_r, v2_r, rdy1, rdy2;
  prod_t  ac_r, bs_r, as_r, bc_r;
  coord_t p1_r, a2_r, b2_r, p2_r;
  logic signed [SUM_W-1:0] sum_a, sum_b;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign sum_a = SUM_W'(ac_r) - SUM_W'(bs_r);
  assign sum_b = SUM_W'(as_r) + SUM_W'(bc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      ac_r <= PROD_W'(a_i) * PROD_W'(cos_i);
      bs_r <= PROD_W'(b_i) * PROD_W'(sin_i);
      as_r <= PROD_W'(a_i) * PROD_W'(sin_i);
      bc_r <= PROD_W'(b_i) * PROD_W'(cos_i);
      p1_r <= p_i;
    end
    if (rdy2 && v1_r) begin
      a2_r <= finish(sum_a);
      b2_r <= finish(sum_b);
      p2_r <= p1_r;
    end
  end

  assign out_valid = v2_r;
  assign a_o = a2_r;
  assign b_o = b2_r;
  assign p_o = p2_r;

  `PTR_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, v1_r)

endmodule

// ===== hdl/point_rotation_xyz.sv =====
// Point rotation top level: APB-style angle registers, sine/cosine unit
// and three plane-rotation stages. Depends on ptr_pkg, ptr_trig, ptr_rot.
//
// Usage: program angle_about_x/y/z at byte addresses 0, 4, 8 (2^16 units
// per turn). Each write starts a sine/cosine recompute for that axis (a
// multiply and a reciprocal multiply for each of the 14 series terms,
// plus setup and rounding); in_ready is low until it ends.
// Points then enter on in_* (valid/ready), one transfer per cycle while
// in_ready is high. Each point passes three rotation stages (about x,
// then y, then z), each a multiply register and a round/saturate
// register. Throughput is one point per cycle while out_ready is high and
// no recompute runs. When the receiver holds out_ready low, each stage
// keeps its item and the pipeline fills its empty slots before in_ready
// drops; nothing is lost or repeated. Synchronous reset empties the
// pipeline, clears the angles, and sets sines to zero and cosines to one.
`include "assert_macros.svh"

module point_rotation_xyz (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ptr_pkg::coord_t in_x_in,
  input  ptr_pkg::coord_t in_y_in,
  input  ptr_pkg::coord_t in_z_in,
  output logic            out_valid,
  input  logic            out_ready,
  output ptr_pkg::coord_t out_x_out,
  output ptr_pkg::coord_t out_y_out,
  output ptr_pkg::coord_t out_z_out,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import ptr_pkg::*;

  angle_t [NUM_AXES-1:0] angle_r;
  axis_t     reg_idx;
  logic      cfg_wr, trig_busy;
  trig_set_t trig;
  logic      r0_ready, r0_valid, r1_ready, r1_valid, r2_ready, r2_valid;
  coord_t    x1, y1, z1, x2, y2, z2;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
    end else if (cfg_wr && (reg_idx < axis_t'(NUM_AXES))) begin
      angle_r[reg_idx] <= pwdata[ANGLE_BITS-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ANGLE_X: prdata = 32'(angle_r[REG_ANGLE_X]);
      REG_ANGLE_Y: prdata = 32'(angle_r[REG_ANGLE_Y]);
      REG_ANGLE_Z: prdata = 32'(angle_r[REG_ANGLE_Z]);
      default:     prdata = '0;
    endcase
  end

  ptr_trig u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_wr),
    .wr_axis (reg_idx),
    .angles  (angle_r),
    .busy    (trig_busy),
    .trig    (trig)
  );

  assign in_ready = r0_ready && !trig_busy;

  // about x: (y, z)
  ptr_rot u_rot_x (
    .clk (clk), .rst_n (rst_n),
    .in_valid (in_valid && !trig_busy), .in_ready (r0_ready),
    .a_i (in_y_in), .b_i (in_z_in), .p_i (in_x_in),
    .sin_i (trig.sin_v[REG_ANGLE_X]), .cos_i (trig.cos_v[REG_ANGLE_X]),
    .out_valid (r0_valid), .out_ready (r1_ready),
    .a_o (y1), .b_o (z1), .p_o (x1)
  );

  // about y: (x, z)
  ptr_rot u_rot_y (
    .clk (clk), .rst_n (rst_n),
    .in_valid (r0_valid), .in_ready (r1_ready),
    .a_i (x1), .b_i (z1), .p_i (y1),
    .sin_i (trig.sin_v[REG_ANGLE_Y]), .cos_i (trig.cos_v[REG_ANGLE_Y]),
    .out_valid (r1_valid), .out_ready (r2_ready),
    .a_o (x2), .b_o (z2), .p_o (y2)
  );

  // about z: (x, y)
  ptr_rot u_rot_z (
    .clk (clk), .rst_n (rst_n),
    .in_valid (r1_valid), .in_ready (r2_ready),
    .a_i (x2), .b_i (y2), .p_i (z2),
    .sin_i (trig.sin_v[REG_ANGLE_Z]), .cos_i (trig.cos_v[REG_ANGLE_Z]),
    .out_valid (r2_valid), .out_ready (out_ready),
    .a_o (out_x_out), .b_o (out_y_out), .p_o (out_z_out)
  );

  assign out_valid = r2_valid;

  `PTR_ASSERT_ALWAYS(a_no_transfer_while_busy, !(in_valid && in_ready && trig_busy))

endmodule
